[hw/rtl/sim_pkg.sv]
package sim_pkg;

   // Build options of the interlock.
   localparam logic TEMP_STOPS_MOTION       = 1'b1;
   localparam logic FAILSAFE_BLOCKS_FORWARD = 1'b1;

   // Event kinds carried on req_tuser.
   localparam logic [2:0] KIND_SENSOR  = 3'd0;
   localparam logic [2:0] KIND_CONTACT = 3'd1;
   localparam logic [2:0] KIND_ESTOP   = 3'd2;
   localparam logic [2:0] KIND_CLEAR   = 3'd3;
   localparam logic [2:0] KIND_BEGIN   = 3'd4;

   // Gas levels.
   localparam logic [1:0] GAS_WARN = 2'd1;
   localparam logic [1:0] GAS_CRIT = 2'd2;

   // Motion commands.
   localparam logic [1:0] CMD_STOP = 2'd0;
   localparam logic [1:0] CMD_FWD  = 2'd1;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_OBS_WARN  = 3'd0;
   localparam logic [2:0] REG_OBS_CRIT  = 3'd1;
   localparam logic [2:0] REG_TEMP_WARN = 3'd2;
   localparam logic [2:0] REG_TEMP_CRIT = 3'd3;
   localparam logic [2:0] REG_TILT_WARN = 3'd4;
   localparam logic [2:0] REG_TILT_CRIT = 3'd5;
   localparam logic [2:0] REG_ROLLOVER  = 3'd6;
   localparam logic [2:0] REG_TIMEOUT   = 3'd7;

   // Status bit positions.
   localparam int ST_US_FAULT = 0;
   localparam int ST_OBS_WARN = 1;
   localparam int ST_OBS_CRIT = 2;
   localparam int ST_GAS_WARN = 3;
   localparam int ST_GAS_CRIT = 4;
   localparam int ST_TMP_WARN = 5;
   localparam int ST_TMP_CRIT = 6;
   localparam int ST_TLT_WARN = 7;
   localparam int ST_TLT_CRIT = 8;
   localparam int ST_BLK_ALL  = 9;
   localparam int ST_BLK_FWD  = 10;
   localparam int ST_EMERG    = 11;
   localparam int ST_WARN     = 12;

   // Previous-flag bit positions.
   localparam int PF_OBS_WARN = 0;
   localparam int PF_GAS_WARN = 1;
   localparam int PF_GAS_CRIT = 2;
   localparam int PF_TMP_WARN = 3;
   localparam int PF_TMP_CRIT = 4;
   localparam int PF_TLT_WARN = 5;
   localparam int PF_TLT_CRIT = 6;
   localparam int PF_US_FAULT = 7;

   // Event bit positions.
   localparam int EV_OBSTACLE = 0;
   localparam int EV_GAS_CRIT = 1;
   localparam int EV_GAS_WARN = 2;
   localparam int EV_TMP_CRIT = 3;
   localparam int EV_TMP_WARN = 4;
   localparam int EV_TLT_CRIT = 5;
   localparam int EV_TLT_WARN = 6;
   localparam int EV_US_FAULT = 7;
   localparam int EV_TIMEOUT  = 8;

   typedef struct packed {
      logic [9:0]        obs_warn_cm;
      logic [9:0]        obs_crit_cm;
      logic signed [7:0] heat_warn_c;
      logic signed [7:0] heat_crit_c;
      logic [7:0]        lean_warn_deg;
      logic [7:0]        lean_crit_deg;
      logic [7:0]        roll_trip_deg;
      logic [15:0]       contact_window_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        now_ms;
      logic               distance_valid;
      logic [9:0]         distance_cm;
      logic [1:0]         gas_level;
      logic               temp_valid;
      logic signed [11:0] temp_deci_c;
      logic               tilt_valid;
      logic signed [8:0]  pitch_deg;
      logic signed [8:0]  roll_deg;
      logic               motor_moving;
      logic [1:0]         motion_command;
   } req_item_type;

   typedef struct packed {
      logic [8:0]  events;
      logic        inhibit_write;
      logic        inhibit_all;
      logic        inhibit_forward;
      logic        stop_motors;
      logic        clear_accepted;
      logic [12:0] status_flags;
      logic        can_move;
   } rsp_item_type;

endpackage

[hw/rtl/safety_interlock_monitor.sv]
// Channel | Direction | Beat contents
// req_*   | in        | tuser: kind; tdata: sensor, contact and command fields
// rsp_*   | out       | tdata: events, inhibits, stop, clear, status, can_move
// csr_*   | in/out    | APB-style access to the eight threshold registers
//
// One event per clock cycle sustained while the rsp side keeps up; each event goes
// through the input register, then decision logic into the result register.
// The single decision stage reads and updates the interlock state in the same
// cycle, so back-to-back events see each other's effects with no bubble.
// Reset is synchronous, active high: clears both stage valids, the status, edge
// and latch state, and loads the threshold registers with their defaults.
// A stalled rsp side holds the result register; the input register still takes
// a beat while the result waits, then req_tready drops until the rsp side moves.
module safety_interlock_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] now_ms, [32] distance_valid, [42:33] distance_cm, [44:43] gas_level,
   // [45] temp_valid, [57:46] temp_deci_c, [58] tilt_valid, [67:59] pitch_deg,
   // [76:68] roll_deg, [77] motor_moving, [79:78] motion_command
   input  logic [79:0] req_tdata,
   // [2:0] kind
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [8:0] events, [9] inhibit_write, [10] inhibit_all, [11] inhibit_forward,
   // [12] stop_motors, [13] clear_accepted, [26:14] status_flags, [27] can_move,
   // [31:28] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sim_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type in_item_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type result;
   rsp_item_type out_ff;
   logic         out_valid_ff, out_valid_in;
   logic         req_beat;
   logic         advance;

   // Unpack the input beat.
   assign req_item.kind           = req_tuser;
   assign req_item.now_ms         = req_tdata[31:0];
   assign req_item.distance_valid = req_tdata[32];
   assign req_item.distance_cm    = req_tdata[42:33];
   assign req_item.gas_level      = req_tdata[44:43];
   assign req_item.temp_valid     = req_tdata[45];
   assign req_item.temp_deci_c    = req_tdata[57:46];
   assign req_item.tilt_valid     = req_tdata[58];
   assign req_item.pitch_deg      = req_tdata[67:59];
   assign req_item.roll_deg       = req_tdata[76:68];
   assign req_item.motor_moving   = req_tdata[77];
   assign req_item.motion_command = req_tdata[79:78];

   // Advance the held event into the result register when that slot frees up.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   sim_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Decision logic and interlock state; state commits only on advance.
   sim_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .item    (in_item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: input loads on a req beat, result on advance; both hold otherwise.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.can_move, out_ff.status_flags, out_ff.clear_accepted,
                        out_ff.stop_motors, out_ff.inhibit_forward, out_ff.inhibit_all,
                        out_ff.inhibit_write, out_ff.events};

endmodule

[hw/rtl/sim_csr.sv]
module sim_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output sim_pkg::cfg_type cfg
);
   import sim_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_OBS_WARN:  cfg_in.obs_warn_cm       = csr_pwdata[9:0];
            REG_OBS_CRIT:  cfg_in.obs_crit_cm       = csr_pwdata[9:0];
            REG_TEMP_WARN: cfg_in.heat_warn_c       = csr_pwdata[7:0];
            REG_TEMP_CRIT: cfg_in.heat_crit_c       = csr_pwdata[7:0];
            REG_TILT_WARN: cfg_in.lean_warn_deg     = csr_pwdata[7:0];
            REG_TILT_CRIT: cfg_in.lean_crit_deg     = csr_pwdata[7:0];
            REG_ROLLOVER:  cfg_in.roll_trip_deg     = csr_pwdata[7:0];
            REG_TIMEOUT:   cfg_in.contact_window_ms = csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_OBS_WARN:  csr_prdata = {22'd0, cfg_ff.obs_warn_cm};
         REG_OBS_CRIT:  csr_prdata = {22'd0, cfg_ff.obs_crit_cm};
         REG_TEMP_WARN: csr_prdata = {24'd0, cfg_ff.heat_warn_c};
         REG_TEMP_CRIT: csr_prdata = {24'd0, cfg_ff.heat_crit_c};
         REG_TILT_WARN: csr_prdata = {24'd0, cfg_ff.lean_warn_deg};
         REG_TILT_CRIT: csr_prdata = {24'd0, cfg_ff.lean_crit_deg};
         REG_ROLLOVER:  csr_prdata = {24'd0, cfg_ff.roll_trip_deg};
         REG_TIMEOUT:   csr_prdata = {16'd0, cfg_ff.contact_window_ms};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obs_warn_cm       <= 10'd30;
         cfg_ff.obs_crit_cm       <= 10'd15;
         cfg_ff.heat_warn_c       <= 8'sd45;
         cfg_ff.heat_crit_c       <= 8'sd60;
         cfg_ff.lean_warn_deg     <= 8'd25;
         cfg_ff.lean_crit_deg     <= 8'd40;
         cfg_ff.roll_trip_deg     <= 8'd60;
         cfg_ff.contact_window_ms <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/sim_core.sv]
module sim_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  sim_pkg::cfg_type      cfg,
   input  sim_pkg::req_item_type item,
   output sim_pkg::rsp_item_type result
);
   import sim_pkg::*;

   logic [12:0] status_ff, status_in;
   logic [7:0]  prev_ff, prev_in;
   logic        manual_ff, manual_in;
   logic        roll_ff, roll_in;
   logic [31:0] last_ff, last_in;

   logic [12:0]        st;
   logic [7:0]         pf;
   logic [8:0]         ev;
   logic signed [12:0] tw_x, tc_x, tw10, tc10, tdc;
   logic [8:0]         p_abs, r_abs, tilt;
   logic               roll_hit, timeout, clear_ok, blk_all;
   logic [31:0]        elapsed;

   function automatic logic [8:0] abs9(input logic signed [8:0] a);
      abs9 = a[8] ? 9'(-a) : 9'(a);
   endfunction

   always_comb begin
      // Thresholds in degrees, scaled to tenths: x*8 + x*2.
      tw_x  = 13'(cfg.heat_warn_c);
      tc_x  = 13'(cfg.heat_crit_c);
      tw10  = (tw_x <<< 3) + (tw_x <<< 1);
      tc10  = (tc_x <<< 3) + (tc_x <<< 1);
      tdc   = 13'(item.temp_deci_c);
      p_abs = abs9(item.pitch_deg);
      r_abs = abs9(item.roll_deg);
      tilt  = item.tilt_valid ? ((p_abs > r_abs) ? p_abs : r_abs) : 9'd0;

      st = '0;
      st[ST_US_FAULT] = !item.distance_valid;
      st[ST_OBS_WARN] = item.distance_valid
                        && (item.distance_cm <= cfg.obs_warn_cm);
      st[ST_OBS_CRIT] = item.distance_valid
                        && (item.distance_cm <= cfg.obs_crit_cm);
      st[ST_GAS_WARN] = (item.gas_level == GAS_WARN) || (item.gas_level == GAS_CRIT);
      st[ST_GAS_CRIT] = (item.gas_level == GAS_CRIT);
      st[ST_TMP_WARN] = item.temp_valid && (tdc >= tw10);
      st[ST_TMP_CRIT] = item.temp_valid && (tdc >= tc10);
      st[ST_TLT_WARN] = item.tilt_valid && (tilt >= {1'b0, cfg.lean_warn_deg});
      st[ST_TLT_CRIT] = item.tilt_valid && (tilt >= {1'b0, cfg.lean_crit_deg});
      roll_hit        = item.tilt_valid && (tilt >= {1'b0, cfg.roll_trip_deg});

      ev = '0;
      ev[EV_OBSTACLE] = st[ST_OBS_WARN] && !prev_ff[PF_OBS_WARN];
      if (st[ST_GAS_CRIT] && !prev_ff[PF_GAS_CRIT]) begin
         ev[EV_GAS_CRIT] = 1'b1;
      end else if (st[ST_GAS_WARN] && !prev_ff[PF_GAS_WARN]) begin
         ev[EV_GAS_WARN] = 1'b1;
      end
      if (st[ST_TMP_CRIT] && !prev_ff[PF_TMP_CRIT]) begin
         ev[EV_TMP_CRIT] = 1'b1;
      end else if (st[ST_TMP_WARN] && !prev_ff[PF_TMP_WARN]) begin
         ev[EV_TMP_WARN] = 1'b1;
      end
      if (st[ST_TLT_CRIT] && !prev_ff[PF_TLT_CRIT]) begin
         ev[EV_TLT_CRIT] = 1'b1;
      end else if (st[ST_TLT_WARN] && !prev_ff[PF_TLT_WARN]) begin
         ev[EV_TLT_WARN] = 1'b1;
      end
      ev[EV_US_FAULT] = st[ST_US_FAULT] && !prev_ff[PF_US_FAULT];

      pf = '0;
      pf[PF_OBS_WARN] = st[ST_OBS_WARN];
      pf[PF_GAS_WARN] = st[ST_GAS_WARN];
      pf[PF_GAS_CRIT] = st[ST_GAS_CRIT];
      pf[PF_TMP_WARN] = st[ST_TMP_WARN];
      pf[PF_TMP_CRIT] = st[ST_TMP_CRIT];
      pf[PF_TLT_WARN] = st[ST_TLT_WARN];
      pf[PF_TLT_CRIT] = st[ST_TLT_CRIT];
      pf[PF_US_FAULT] = st[ST_US_FAULT];

      blk_all = manual_ff || roll_ff || roll_hit || st[ST_GAS_CRIT] || st[ST_TLT_CRIT]
                || (st[ST_TMP_CRIT] && TEMP_STOPS_MOTION);
      st[ST_BLK_ALL] = blk_all;
      st[ST_EMERG]   = blk_all;
      st[ST_BLK_FWD] = blk_all || st[ST_OBS_CRIT]
                       || (st[ST_US_FAULT] && FAILSAFE_BLOCKS_FORWARD);
      st[ST_WARN]    = st[ST_EMERG] || st[ST_OBS_WARN] || st[ST_GAS_WARN]
                       || st[ST_TMP_WARN] || st[ST_TLT_WARN] || st[ST_US_FAULT];

      // Wrapping difference covers a time counter that rolled over.
      elapsed = item.now_ms - last_ff;
      timeout = item.motor_moving && (elapsed >= 32'(cfg.contact_window_ms));
      ev[EV_TIMEOUT] = timeout;

      clear_ok = !(status_ff[ST_GAS_CRIT] || status_ff[ST_TLT_CRIT])
                 && !(status_ff[ST_TMP_CRIT] && TEMP_STOPS_MOTION);
   end

   always_comb begin
      status_in = status_ff;
      prev_in   = prev_ff;
      manual_in = manual_ff;
      roll_in   = roll_ff;
      last_in   = last_ff;
      result    = '0;
      unique case (item.kind)
         KIND_SENSOR: begin
            status_in              = st;
            prev_in                = pf;
            roll_in                = roll_ff || roll_hit;
            result.events          = ev;
            result.inhibit_write   = 1'b1;
            result.inhibit_all     = st[ST_BLK_ALL];
            result.inhibit_forward = st[ST_BLK_FWD];
            result.stop_motors     = timeout;
         end
         KIND_CONTACT: begin
            last_in = item.now_ms;
         end
         KIND_ESTOP: begin
            manual_in              = 1'b1;
            result.inhibit_write   = 1'b1;
            result.inhibit_all     = 1'b1;
            result.inhibit_forward = 1'b1;
            result.stop_motors     = 1'b1;
         end
         KIND_CLEAR: begin
            if (clear_ok) begin
               manual_in             = 1'b0;
               roll_in               = 1'b0;
               result.clear_accepted = 1'b1;
            end
         end
         KIND_BEGIN: begin
            last_in                = item.now_ms;
            status_in[ST_BLK_FWD]  = 1'b1;
            status_in[ST_US_FAULT] = 1'b1;
            status_in[ST_WARN]     = 1'b1;
            result.inhibit_write   = 1'b1;
            result.inhibit_forward = 1'b1;
         end
         default: begin
         end
      endcase
      result.status_flags = status_in;
      if (item.motion_command == CMD_STOP) begin
         result.can_move = 1'b1;
      end else if (status_in[ST_BLK_ALL]) begin
         result.can_move = 1'b0;
      end else begin
         result.can_move = (item.motion_command != CMD_FWD) || !status_in[ST_BLK_FWD];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         prev_ff   <= '0;
         manual_ff <= 1'b0;
         roll_ff   <= 1'b0;
         last_ff   <= '0;
      end else if (advance) begin
         status_ff <= status_in;
         prev_ff   <= prev_in;
         manual_ff <= manual_in;
         roll_ff   <= roll_in;
         last_ff   <= last_in;
      end
   end

endmodule

[hw/rtl/sim_checker.sv]
module sim_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // Inhibit values go out only with an inhibit write.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[9] |-> !rsp_tdata[10] && !rsp_tdata[11])
      else $error("inhibit value without inhibit write");

   // Events only come from sensor updates, which always write inhibits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[8:0] != 9'd0) |-> rsp_tdata[9])
      else $error("events on a beat without inhibit write");

   // Block-all always carries block-forward and emergency active.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23] |-> rsp_tdata[24] && rsp_tdata[25])
      else $error("block-all without block-forward or emergency");

   // No result right after reset.
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind safety_interlock_monitor sim_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/safety_interlock_monitor_test.sv]
module safety_interlock_monitor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sim_pkg::*;

   // Codes the package leaves unnamed.
   localparam logic [1:0] GAS_CLEAR    = 2'd0;
   localparam logic [1:0] GAS_RESERVED = 2'd3;
   localparam logic [1:0] CMD_OTHER    = 2'd2;

   // Receiver hold-off length that fills the two-stage pipe and stalls req.
   localparam int HOLD_CYCLES = 80;

   // Shadow of the interlock: thresholds, status, edge memory and latches,
   // plus the verdicts still owed by the block.
   class interlock_verdicts;
      cfg_type      cfg;
      logic [12:0]  status;
      logic [7:0]   prev_flags;
      bit           manual_latch;
      bit           roll_latch;
      logic [31:0]  last_contact;
      rsp_item_type awaited_verdicts[$];
      int           mismatch_count;

      function new();
         cfg.obs_warn_cm       = 10'd30;
         cfg.obs_crit_cm       = 10'd15;
         cfg.heat_warn_c       = 8'sd45;
         cfg.heat_crit_c       = 8'sd60;
         cfg.lean_warn_deg     = 8'd25;
         cfg.lean_crit_deg     = 8'd40;
         cfg.roll_trip_deg     = 8'd60;
         cfg.contact_window_ms = 16'd1000;
         status         = '0;
         prev_flags     = '0;
         manual_latch   = 1'b0;
         roll_latch     = 1'b0;
         last_contact   = '0;
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_OBS_WARN:  cfg.obs_warn_cm       = value[9:0];
            REG_OBS_CRIT:  cfg.obs_crit_cm       = value[9:0];
            REG_TEMP_WARN: cfg.heat_warn_c       = value[7:0];
            REG_TEMP_CRIT: cfg.heat_crit_c       = value[7:0];
            REG_TILT_WARN: cfg.lean_warn_deg     = value[7:0];
            REG_TILT_CRIT: cfg.lean_crit_deg     = value[7:0];
            REG_ROLLOVER:  cfg.roll_trip_deg     = value[7:0];
            REG_TIMEOUT:   cfg.contact_window_ms = value[15:0];
            default: ;
         endcase
      endfunction

      function void note_event(req_item_type it);
         rsp_item_type r;
         logic [12:0]  st;
         logic [7:0]   pf;
         logic [31:0]  elapsed;
         int           deci, warn_deci, crit_deci, p, q, lean;
         r = '0;
         case (it.kind)
            KIND_SENSOR: begin
               st = '0;
               deci      = $signed(it.temp_deci_c);
               warn_deci = $signed(cfg.heat_warn_c) * 10;
               crit_deci = $signed(cfg.heat_crit_c) * 10;
               st[ST_US_FAULT] = !it.distance_valid;
               st[ST_OBS_WARN] = it.distance_valid &&
                                 it.distance_cm <= cfg.obs_warn_cm;
               st[ST_OBS_CRIT] = it.distance_valid &&
                                 it.distance_cm <= cfg.obs_crit_cm;
               st[ST_GAS_WARN] = it.gas_level == GAS_WARN || it.gas_level == GAS_CRIT;
               st[ST_GAS_CRIT] = it.gas_level == GAS_CRIT;
               st[ST_TMP_WARN] = it.temp_valid && deci >= warn_deci;
               st[ST_TMP_CRIT] = it.temp_valid && deci >= crit_deci;
               // invalid tilt leaves every tilt flag clear
               if (it.tilt_valid) begin
                  p = $signed(it.pitch_deg);
                  q = $signed(it.roll_deg);
                  if (p < 0) p = -p;
                  if (q < 0) q = -q;
                  lean = (p > q) ? p : q;
                  st[ST_TLT_WARN] = lean >= int'(cfg.lean_warn_deg);
                  st[ST_TLT_CRIT] = lean >= int'(cfg.lean_crit_deg);
                  if (lean >= int'(cfg.roll_trip_deg)) roll_latch = 1'b1;
               end
               // rising edges, critical shadows warning
               r.events[EV_OBSTACLE] = st[ST_OBS_WARN] && !prev_flags[PF_OBS_WARN];
               if (st[ST_GAS_CRIT] && !prev_flags[PF_GAS_CRIT])
                  r.events[EV_GAS_CRIT] = 1'b1;
               else if (st[ST_GAS_WARN] && !prev_flags[PF_GAS_WARN])
                  r.events[EV_GAS_WARN] = 1'b1;
               if (st[ST_TMP_CRIT] && !prev_flags[PF_TMP_CRIT])
                  r.events[EV_TMP_CRIT] = 1'b1;
               else if (st[ST_TMP_WARN] && !prev_flags[PF_TMP_WARN])
                  r.events[EV_TMP_WARN] = 1'b1;
               if (st[ST_TLT_CRIT] && !prev_flags[PF_TLT_CRIT])
                  r.events[EV_TLT_CRIT] = 1'b1;
               else if (st[ST_TLT_WARN] && !prev_flags[PF_TLT_WARN])
                  r.events[EV_TLT_WARN] = 1'b1;
               r.events[EV_US_FAULT] = st[ST_US_FAULT] && !prev_flags[PF_US_FAULT];
               pf = '0;
               pf[PF_OBS_WARN] = st[ST_OBS_WARN];
               pf[PF_GAS_WARN] = st[ST_GAS_WARN];
               pf[PF_GAS_CRIT] = st[ST_GAS_CRIT];
               pf[PF_TMP_WARN] = st[ST_TMP_WARN];
               pf[PF_TMP_CRIT] = st[ST_TMP_CRIT];
               pf[PF_TLT_WARN] = st[ST_TLT_WARN];
               pf[PF_TLT_CRIT] = st[ST_TLT_CRIT];
               pf[PF_US_FAULT] = st[ST_US_FAULT];
               prev_flags = pf;
               if (manual_latch || roll_latch || st[ST_GAS_CRIT] || st[ST_TLT_CRIT] ||
                   (st[ST_TMP_CRIT] && TEMP_STOPS_MOTION)) begin
                  st[ST_BLK_ALL] = 1'b1;
                  st[ST_EMERG]   = 1'b1;
               end
               if (st[ST_BLK_ALL] || st[ST_OBS_CRIT] ||
                   (st[ST_US_FAULT] && FAILSAFE_BLOCKS_FORWARD))
                  st[ST_BLK_FWD] = 1'b1;
               st[ST_WARN] = st[ST_EMERG] | st[ST_OBS_WARN] | st[ST_GAS_WARN] |
                             st[ST_TMP_WARN] | st[ST_TLT_WARN] | st[ST_US_FAULT];
               status = st;
               elapsed = it.now_ms - last_contact;
               if (it.motor_moving && elapsed >= {16'd0, cfg.contact_window_ms}) begin
                  r.stop_motors         = 1'b1;
                  r.events[EV_TIMEOUT]  = 1'b1;
               end
               r.inhibit_write   = 1'b1;
               r.inhibit_all     = status[ST_BLK_ALL];
               r.inhibit_forward = status[ST_BLK_FWD];
            end
            KIND_CONTACT: last_contact = it.now_ms;
            KIND_ESTOP: begin
               manual_latch      = 1'b1;
               r.inhibit_write   = 1'b1;
               r.inhibit_all     = 1'b1;
               r.inhibit_forward = 1'b1;
               r.stop_motors     = 1'b1;
            end
            KIND_CLEAR: begin
               if (!status[ST_GAS_CRIT] && !status[ST_TLT_CRIT] &&
                   !(status[ST_TMP_CRIT] && TEMP_STOPS_MOTION)) begin
                  manual_latch     = 1'b0;
                  roll_latch       = 1'b0;
                  r.clear_accepted = 1'b1;
               end
            end
            KIND_BEGIN: begin
               last_contact        = it.now_ms;
               status[ST_BLK_FWD]  = 1'b1;
               status[ST_US_FAULT] = 1'b1;
               status[ST_WARN]     = 1'b1;
               r.inhibit_write     = 1'b1;
               r.inhibit_forward   = 1'b1;
            end
            default: ;
         endcase
         r.status_flags = status;
         if (it.motion_command == CMD_STOP)
            r.can_move = 1'b1;
         else if (status[ST_BLK_ALL])
            r.can_move = 1'b0;
         else
            r.can_move = it.motion_command != CMD_FWD || !status[ST_BLK_FWD];
         awaited_verdicts.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      function void check_verdict(rsp_item_type got);
         rsp_item_type want;
         if (awaited_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result beat with nothing awaited: %0h", $time, got);
            return;
         end
         want = awaited_verdicts.pop_front();
         compare_field("events", 32'(want.events), 32'(got.events));
         compare_field("inhibit_write", 32'(want.inhibit_write), 32'(got.inhibit_write));
         compare_field("inhibit_all", 32'(want.inhibit_all), 32'(got.inhibit_all));
         compare_field("inhibit_forward", 32'(want.inhibit_forward),
                       32'(got.inhibit_forward));
         compare_field("stop_motors", 32'(want.stop_motors), 32'(got.stop_motors));
         compare_field("clear_accepted", 32'(want.clear_accepted),
                       32'(got.clear_accepted));
         compare_field("status_flags", 32'(want.status_flags), 32'(got.status_flags));
         compare_field("can_move", 32'(want.can_move), 32'(got.can_move));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [31:0] now_ms, [32] distance_valid, [42:33] distance_cm, [44:43] gas_level,
   // [45] temp_valid, [57:46] temp_deci_c, [58] tilt_valid, [67:59] pitch_deg,
   // [76:68] roll_deg, [77] motor_moving, [79:78] motion_command
   logic [79:0] req_tdata = '0;
   // [2:0] kind
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [8:0] events, [9] inhibit_write, [10] inhibit_all, [11] inhibit_forward,
   // [12] stop_motors, [13] clear_accepted, [26:14] status_flags, [27] can_move
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   interlock_verdicts verdicts;
   bit                no_gaps = 1'b0;   // suppress idling on both sides
   bit                hold_off = 1'b0;  // ask the receiver for a long stall
   logic [31:0]       wall_ms;          // running millisecond clock for stimulus

   safety_interlock_monitor u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Fail the run if it hangs anywhere.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: accept most cycles, stall at random, and on request hold off
   // for a long stretch so the block backs up into req_tready.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_tready <= no_gaps || $urandom_range(99) >= 9;
         end
      end
   end

   // Sample both channels at the edge: feed accepted req beats to the shadow,
   // check accepted rsp beats against the oldest awaited verdict.
   always @(posedge clock) begin : bus_watch
      req_item_type seen;
      rsp_item_type got;
      if (!reset) begin
         // check before noting: a verdict can never belong to this edge's beat
         if (rsp_tvalid && rsp_tready) begin
            got.events          = rsp_tdata[8:0];
            got.inhibit_write   = rsp_tdata[9];
            got.inhibit_all     = rsp_tdata[10];
            got.inhibit_forward = rsp_tdata[11];
            got.stop_motors     = rsp_tdata[12];
            got.clear_accepted  = rsp_tdata[13];
            got.status_flags    = rsp_tdata[26:14];
            got.can_move        = rsp_tdata[27];
            verdicts.check_verdict(got);
         end
         if (req_tvalid && req_tready) begin
            seen.kind           = req_tuser;
            seen.now_ms         = req_tdata[31:0];
            seen.distance_valid = req_tdata[32];
            seen.distance_cm    = req_tdata[42:33];
            seen.gas_level      = req_tdata[44:43];
            seen.temp_valid     = req_tdata[45];
            seen.temp_deci_c    = req_tdata[57:46];
            seen.tilt_valid     = req_tdata[58];
            seen.pitch_deg      = req_tdata[67:59];
            seen.roll_deg       = req_tdata[76:68];
            seen.motor_moving   = req_tdata[77];
            seen.motion_command = req_tdata[79:78];
            verdicts.note_event(seen);
         end
      end
   end

   // Offer one beat, with random idle cycles ahead of it; return at the edge
   // that accepts it.
   task automatic push_beat(input req_item_type it);
      while (!no_gaps && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {it.motion_command, it.motor_moving, it.roll_deg, it.pitch_deg,
                     it.tilt_valid, it.temp_deci_c, it.temp_valid, it.gas_level,
                     it.distance_cm, it.distance_valid, it.now_ms};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every awaited verdict is in, then let the bus idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts.awaited_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup phase, access phase, then an idle gap before the next transfer.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      verdicts.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic load_thresholds(input int obw, input int obc, input int tw, input int tc,
                                  input int tiw, input int tic, input int rol,
                                  input int tmo);
      drain();
      csr_write(REG_OBS_WARN, 32'(obw));
      csr_write(REG_OBS_CRIT, 32'(obc));
      csr_write(REG_TEMP_WARN, 32'(tw));
      csr_write(REG_TEMP_CRIT, 32'(tc));
      csr_write(REG_TILT_WARN, 32'(tiw));
      csr_write(REG_TILT_CRIT, 32'(tic));
      csr_write(REG_ROLLOVER, 32'(rol));
      csr_write(REG_TIMEOUT, 32'(tmo));
   endtask

   // A quiet sensor reading: everything valid and well inside the defaults.
   function automatic req_item_type calm(logic [2:0] kind, logic [31:0] at_ms);
      req_item_type it;
      it.kind           = kind;
      it.now_ms         = at_ms;
      it.distance_valid = 1'b1;
      it.distance_cm    = 10'd500;
      it.gas_level      = GAS_CLEAR;
      it.temp_valid     = 1'b1;
      it.temp_deci_c    = 12'sd200;
      it.tilt_valid     = 1'b1;
      it.pitch_deg      = 9'sd3;
      it.roll_deg       = -9'sd2;
      it.motor_moving   = 1'b0;
      it.motion_command = CMD_FWD;
      return it;
   endfunction

   function automatic int near(int center, int spread, int lo, int hi);
      int v;
      v = center - spread + int'($urandom_range(2 * spread));
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   // Random events biased toward the thresholds in force, so edges, latches,
   // refused clears and timeouts all come up often.
   task automatic run_random(input int count, input int stall_at);
      req_item_type it;
      int           pick, c, a, other, p, q;
      for (int n = 0; n < count; n++) begin
         if (n == stall_at) hold_off = 1'b1;
         // advance the clock; now and then jump anywhere to reach every bit and wrap
         if ($urandom_range(99) < 2) wall_ms = $urandom();
         else wall_ms += $urandom_range(400);
         it.now_ms = wall_ms;

         it.distance_valid = $urandom_range(99) < 88;
         c = $urandom_range(1) ? int'(verdicts.cfg.obs_warn_cm)
                               : int'(verdicts.cfg.obs_crit_cm);
         if ($urandom_range(1)) it.distance_cm = 10'(near(c, 3, 0, 1023));
         else it.distance_cm = 10'($urandom_range(1023));

         pick = $urandom_range(99);
         if (pick < 62) it.gas_level = GAS_CLEAR;
         else if (pick < 82) it.gas_level = GAS_WARN;
         else if (pick < 92) it.gas_level = GAS_CRIT;
         else it.gas_level = GAS_RESERVED;

         it.temp_valid = $urandom_range(99) < 88;
         pick = $urandom_range(99);
         if (pick < 40) begin
            if ($urandom_range(1)) c = $signed(verdicts.cfg.heat_warn_c) * 10;
            else c = $signed(verdicts.cfg.heat_crit_c) * 10;
            c = near(c, 12, -400, 1250);
         end else if (pick < 85) begin
            c = -400 + int'($urandom_range(800));
         end else begin
            c = -400 + int'($urandom_range(1650));
         end
         it.temp_deci_c = c[11:0];

         it.tilt_valid = $urandom_range(99) < 88;
         pick = $urandom_range(99);
         if (pick < 15) a = near(int'(verdicts.cfg.lean_warn_deg), 2, 0, 180);
         else if (pick < 30) a = near(int'(verdicts.cfg.lean_crit_deg), 2, 0, 180);
         else if (pick < 38) a = near(int'(verdicts.cfg.roll_trip_deg), 2, 0, 180);
         else if (pick < 70) a = $urandom_range(10);
         else a = $urandom_range(180);
         other = $urandom_range(a);
         if ($urandom_range(1)) begin
            p = a;
            q = other;
         end else begin
            p = other;
            q = a;
         end
         if ($urandom_range(1)) p = -p;
         if ($urandom_range(1)) q = -q;
         it.pitch_deg = p[8:0];
         it.roll_deg  = q[8:0];

         it.motor_moving   = 1'($urandom_range(1));
         it.motion_command = 2'($urandom_range(2));

         pick = $urandom_range(99);
         if (pick < 58) it.kind = KIND_SENSOR;
         else if (pick < 72) it.kind = KIND_CONTACT;
         else if (pick < 77) it.kind = KIND_ESTOP;
         else if (pick < 89) it.kind = KIND_CLEAR;
         else if (pick < 97) it.kind = KIND_BEGIN;
         else it.kind = KIND_BEGIN + 3'($urandom_range(1, 3));
         push_beat(it);
      end
   endtask

   initial begin
      req_item_type it;
      logic [2:0]   k;
      int           obw, obc, tw, tc, tiw, tic;
      verdicts = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk with the reset thresholds.
      push_beat(calm(KIND_BEGIN, 32'd100));
      push_beat(calm(KIND_SENSOR, 32'd200));
      it = calm(KIND_SENSOR, 32'd210);
      it.distance_cm = 10'd30;                 // obstacle warning on the boundary
      push_beat(it);
      it = calm(KIND_SENSOR, 32'd220);
      it.distance_cm = 10'd15;                 // forward blocked
      it.motion_command = CMD_OTHER;
      push_beat(it);
      it = calm(KIND_SENSOR, 32'd230);
      it.distance_valid = 1'b0;                // ultrasonic fault
      it.distance_cm = 10'd1023;
      push_beat(it);
      it = calm(KIND_SENSOR, 32'd240);
      it.gas_level = GAS_CRIT;                 // critical shadows warning
      it.motion_command = CMD_OTHER;
      push_beat(it);
      it = calm(KIND_SENSOR, 32'd250);
      it.gas_level = GAS_WARN;
      push_beat(it);
      it = calm(KIND_SENSOR, 32'd260);
      it.gas_level = GAS_RESERVED;             // reads as normal
      push_beat(it);
      it = calm(KIND_SENSOR, 32'd270);
      it.temp_deci_c = 12'sd450;
      push_beat(it);
      it = calm(KIND_SENSOR, 32'd280);
      it.temp_deci_c = 12'sd1250;
      push_beat(it);
      push_beat(calm(KIND_CLEAR, 32'd290));    // refused: temperature critical
      it = calm(KIND_SENSOR, 32'd300);
      it.temp_deci_c = -12'sd400;
      it.pitch_deg = -9'sd180;                 // rollover, tilt critical
      it.roll_deg = 9'sd180;
      push_beat(it);
      push_beat(calm(KIND_CLEAR, 32'd310));    // refused: tilt critical
      push_beat(calm(KIND_SENSOR, 32'd320));   // rollover still latched
      push_beat(calm(KIND_CLEAR, 32'd330));    // accepted
      push_beat(calm(KIND_SENSOR, 32'd340));
      push_beat(calm(KIND_ESTOP, 32'd350));
      push_beat(calm(KIND_SENSOR, 32'd360));   // manual stop holds block-all
      push_beat(calm(KIND_CLEAR, 32'd370));
      push_beat(calm(KIND_CONTACT, 32'd5000));
      it = calm(KIND_SENSOR, 32'd5999);
      it.motor_moving = 1'b1;                  // one short of the timeout
      push_beat(it);
      it.now_ms = 32'd6000;                    // timeout exactly
      push_beat(it);
      push_beat(calm(KIND_CONTACT, 32'hFFFF_FF00));
      it = calm(KIND_SENSOR, 32'h0000_0100);
      it.motor_moving = 1'b1;                  // elapsed time wraps, no timeout
      it.tilt_valid = 1'b0;                    // angles ignored
      it.pitch_deg = -9'sd180;
      push_beat(it);
      k = KIND_BEGIN;
      repeat (3) begin
         k++;
         it = calm(k, 32'd7000);               // unknown kinds change nothing
         it.motion_command = CMD_OTHER;
         push_beat(it);
      end

      wall_ms = $urandom();
      run_random(240, -1);

      // Lowest thresholds everywhere.
      load_thresholds(0, 0, -40, -40, 0, 0, 0, 0);
      run_random(150, -1);

      // Highest thresholds; hold the receiver off partway through.
      load_thresholds(1023, 1023, 125, 125, 180, 180, 180, 65535);
      run_random(260, 60);

      // Random but ordered settings; the first runs without any idling.
      for (int ph = 0; ph < 4; ph++) begin
         obw = $urandom_range(10, 300);
         obc = $urandom_range(obw);
         tw  = int'($urandom_range(120)) - 40;
         tc  = tw + int'($urandom_range(125 - tw));
         tiw = $urandom_range(5, 60);
         tic = tiw + int'($urandom_range(40));
         load_thresholds(obw, obc, tw, tc, tiw, tic,
                         tic + int'($urandom_range(180 - tic)), $urandom_range(3000));
         no_gaps = (ph == 0);
         run_random(250, -1);
      end
      no_gaps = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (verdicts.mismatch_count == 0 && verdicts.awaited_verdicts.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
hw/rtl/sim_pkg.sv
hw/rtl/sim_csr.sv
hw/rtl/sim_core.sv
hw/rtl/safety_interlock_monitor.sv
hw/rtl/sim_checker.sv
tb/safety_interlock_monitor_test.sv
